// ----- src/jiis_pkg.sv -----
// Package for the Julia inverse-iteration step block.
// Holds shared widths, register indexes and reset values; no dependencies.
package jiis_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned ZBits = 20;
  localparam int unsigned CBits = 19;
  localparam int unsigned SBits = 15;
  localparam int unsigned CentreBits = 12;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 19;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_C_REAL      = 2'd0,
    REG_C_IMAG      = 2'd1,
    REG_HALF_WIDTH  = 2'd2,
    REG_HALF_HEIGHT = 2'd3
  } cfg_reg_e;

  localparam logic [CentreBits-1:0] HalfWidthReset  = 12'd512;
  localparam logic [CentreBits-1:0] HalfHeightReset = 12'd384;

endpackage

// ----- src/jiis_if.sv -----
// Channel interfaces for the Julia inverse-iteration step block.
// Field widths are written as literals and not taken from jiis_pkg.
interface jiis_in_if;
  logic valid;
  logic ready;
  logic restart_walk;
  logic flip_root;
  modport source (output valid, restart_walk, flip_root, input ready);
  modport sink (input valid, restart_walk, flip_root, output ready);
endinterface

interface jiis_out_if;
  logic        valid;
  logic        ready;
  logic signed [19:0] z_real;
  logic signed [19:0] z_imag;
  logic signed [14:0] screen_x;
  logic signed [14:0] screen_y;
  modport source (output valid, z_real, z_imag, screen_x, screen_y, input ready);
  modport sink (input valid, z_real, z_imag, screen_x, screen_y, output ready);
endinterface

interface jiis_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [18:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/jiis_isqrt.sv -----
// Iterative floor square root, two radicand bits per cycle.
// Self-contained; no package dependencies.
module jiis_isqrt #(
  parameter int unsigned Width = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [Width-1:0]     radicand_i,
  output logic                 done_o,
  output logic [Width/2-1:0]   root_o
);

  localparam int unsigned Steps = Width / 2;
  localparam int unsigned CntBits = $clog2(Steps + 1);

  logic [Width-1:0]   rem_q, rem_d;
  logic [Width-1:0]   rad_q, rad_d;
  logic [Width/2-1:0] root_q, root_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [Width+1:0]   trial;
  logic [Width+1:0]   shifted;
  logic [Width-1:0]   step_rem;
  logic [Width/2-1:0] step_root;

  // One restoring step: bring down two bits and try root*4+1.
  always_comb begin
    shifted = {rem_q, rad_q[Width-1:Width-2]};
    trial   = {root_q, 2'b01};
    if (shifted >= trial) begin
      step_rem  = Width'(shifted - trial);
      step_root = {root_q[Width/2-2:0], 1'b1};
    end else begin
      step_rem  = Width'(shifted);
      step_root = {root_q[Width/2-2:0], 1'b0};
    end
    rem_d   = rem_q;
    rad_d   = rad_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      rad_d  = radicand_i;
      root_d = '0;
      cnt_d  = CntBits'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[Width-3:0], 2'b00};
      rem_d  = step_rem;
      root_d = step_root;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
  end

  // The final root is the outcome of the last step, shown while done_o is high.
  assign done_o = busy_q && (cnt_q == CntBits'(1));
  assign root_o = step_root;
endmodule

// ----- src/julia_inverse_iteration_step.sv -----
// Julia inverse-iteration step: top level with sequencer and output stage.
// Depends on jiis_pkg, the jiis interfaces and jiis_isqrt.
//
// A new request is taken only once the previous one has finished. After acceptance
// the magnitude square is formed and registered, then three floor square roots of a
// 64-bit radicand run one after another on a single shared unit that settles two
// radicand bits per cycle, each started by loading its radicand; the ST_MUL state then
// forms the screen products and ST_POS the saturated screen result. The result waits
// in the output register; the next request is taken once that register is free or
// being read in the same cycle. Configuration writes are always taken and should only
// be issued while no request is in flight.
module julia_inverse_iteration_step #(
  parameter int unsigned FracBits = jiis_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jiis_cfg_if.sink    cfg,
  jiis_in_if.sink     in_ch,
  jiis_out_if.source  out_ch
);
  import jiis_pkg::*;

  localparam int unsigned RootW = 64;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MAG  = 6'b000010,
    ST_RE   = 6'b000100,
    ST_IM   = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_POS  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [CBits-1:0]  c_re_q, c_im_q;
  logic [CentreBits-1:0]    hw_q, hh_q;
  logic signed [ZBits-1:0]  pr_q, pi_q;
  logic signed [ZBits+1:0]  a_q, b_q;
  logic                     flip_q;
  logic [RootW/2-1:0]       m_q, re_q;
  logic signed [ZBits+CentreBits:0] px_q, py_q;
  logic                     ovalid_q;
  logic signed [ZBits-1:0]  oz_re_q, oz_im_q;
  logic signed [SBits-1:0]  osx_q, osy_q;
  logic [RootW-1:0]         mag_rad_q;
  logic                     go_q;
  logic                     kick_q;

  logic                     sq_start, sq_done;
  logic [RootW-1:0]         sq_rad;
  logic [RootW/2-1:0]       sq_root;
  logic                     in_acc;

  // Configuration register file.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_re_q <= '0;
      c_im_q <= '0;
      hw_q   <= HalfWidthReset;
      hh_q   <= HalfHeightReset;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_C_REAL:      c_re_q <= cfg.data;
        REG_C_IMAG:      c_im_q <= cfg.data;
        REG_HALF_WIDTH:  hw_q   <= cfg.data[CentreBits-1:0];
        REG_HALF_HEIGHT: hh_q   <= cfg.data[CentreBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_q == ST_IDLE) && !go_q && (!ovalid_q || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Magnitude square and radicand selection for the shared square-root unit.
  logic [ZBits+1:0]   ua, ub;
  logic [2*ZBits+3:0] ua_sq, ub_sq;
  logic [RootW-1:0]   mpa, mma;
  always_comb begin
    ua    = a_q[ZBits+1] ? -a_q : a_q;
    ub    = b_q[ZBits+1] ? -b_q : b_q;
    ua_sq = ua * ua;
    ub_sq = ub * ub;
    mpa = RootW'($signed({1'b0, m_q}) + a_q);
    mma = RootW'($signed({1'b0, m_q}) - a_q);
    sq_rad = '0;
    unique case (state_q)
      ST_MAG:  sq_rad = mag_rad_q;
      ST_RE:   sq_rad = (mpa << FracBits) >> 1;
      ST_IM:   sq_rad = (mma << FracBits) >> 1;
      default: sq_rad = '0;
    endcase
  end

  // Each root is started from kick_q, registered at the same edge as its radicand's source.
  assign sq_start = kick_q;

  jiis_isqrt #(.Width(RootW)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // Saturation to the point width.
  function automatic logic signed [ZBits-1:0] sat_z(input logic signed [RootW/2+1:0] v);
    logic signed [RootW/2+1:0] hi, lo;
    hi = (RootW/2+2)'(2**(ZBits-1) - 1);
    lo = -(RootW/2+2)'(2**(ZBits-1));
    if (v > hi) return ZBits'(hi);
    if (v < lo) return ZBits'(lo);
    return ZBits'(v);
  endfunction

  function automatic logic signed [SBits-1:0] scr(input logic [CentreBits-1:0] c,
                                                 input logic signed [ZBits+CentreBits:0] p);
    logic signed [ZBits+CentreBits:0] q, s;
    q = p[ZBits+CentreBits] ? -((-p) >>> FracBits) : (p >>> FracBits);
    s = q + $signed({1'b0, c});
    if (s > $signed((ZBits+CentreBits+1)'(2**(SBits-1) - 1)))
      return SBits'(2**(SBits-1) - 1);
    if (s < $signed(-(ZBits+CentreBits+1)'(2**(SBits-1))))
      return SBits'(-(2**(SBits-1)));
    return SBits'(s);
  endfunction

  logic signed [RootW/2+1:0] re_s, im_s;
  always_comb begin
    re_s = $signed({2'b00, re_q});
    im_s = $signed({2'b00, sq_root});
    if (b_q[ZBits+1]) im_s = -im_s;
    if (flip_q) begin
      re_s = -re_s;
      im_s = -im_s;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (go_q) state_d = ST_MAG;
      ST_MAG:  if (sq_done) state_d = ST_RE;
      ST_RE:   if (sq_done) state_d = ST_IM;
      ST_IM:   if (sq_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_POS;
      ST_POS:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      go_q     <= 1'b0;
      kick_q   <= 1'b0;
      ovalid_q <= 1'b0;
      pr_q     <= '0;
      pi_q     <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= in_acc;
      kick_q  <= go_q || (sq_done && (state_q == ST_MAG || state_q == ST_RE));
      if (state_q == ST_POS) ovalid_q <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      if (state_q == ST_IM && sq_done) begin
        pr_q <= sat_z(re_s);
        pi_q <= sat_z(im_s);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q    <= in_ch.restart_walk ? -(ZBits+2)'(c_re_q) : (ZBits+2)'(pr_q) - (ZBits+2)'(c_re_q);
      b_q    <= in_ch.restart_walk ? -(ZBits+2)'(c_im_q) : (ZBits+2)'(pi_q) - (ZBits+2)'(c_im_q);
      flip_q <= in_ch.flip_root;
    end
    if (go_q) mag_rad_q <= RootW'({1'b0, ua_sq} + {1'b0, ub_sq});
    if (state_q == ST_MAG && sq_done) m_q <= sq_root;
    if (state_q == ST_RE && sq_done) re_q <= sq_root;
    if (state_q == ST_MUL) begin
      px_q <= $signed({1'b0, hw_q >> 1}) * pr_q;
      py_q <= $signed({1'b0, hh_q >> 1}) * pi_q;
    end
    if (state_q == ST_POS) begin
      oz_re_q <= pr_q;
      oz_im_q <= pi_q;
      osx_q   <= scr(hw_q, px_q);
      osy_q   <= scr(hh_q, py_q);
    end
  end

  // Result channel.
  assign out_ch.valid    = ovalid_q;
  assign out_ch.z_real   = oz_re_q;
  assign out_ch.z_imag   = oz_im_q;
  assign out_ch.screen_x = osx_q;
  assign out_ch.screen_y = osy_q;
endmodule

// ----- src/jiis_checker.sv -----
// Port-level checker for the Julia inverse-iteration step block, with its bind.
// Depends on the top level's interface ports only.
module jiis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // After a request is taken the block is busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted during a step");

  // No result appears in the cycle right after a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");
endmodule

bind julia_inverse_iteration_step jiis_checker u_jiis_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
